FILE: rtl/rrss_pkg.sv
`default_nettype none
package rrss_pkg;

  localparam int MAX_THREADS = 16;
  localparam int IDX_W       = $clog2(MAX_THREADS);
  localparam int N_W         = IDX_W + 1;
  localparam int TIME_W      = 64;
  localparam int TID_W       = 4;
  localparam int TCNT_W      = 5;
  localparam int FUNC_W      = 2;

  localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_WAKE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_DONE = 2'd2;

  localparam logic [TCNT_W-1:0] TCNT_RESET = 5'd1;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [N_W-1:0]    ring_n_t;
  typedef logic [TIME_W-1:0] time_t;

  typedef struct packed {
    logic  en;
    idx_t  addr;
    time_t data;
  } wake_wr_t;

  typedef struct packed {
    logic awake;
    idx_t adv;
  } scan_res_t;

  function automatic ring_n_t ring_size(input logic [TCNT_W-1:0] tc);
    ring_n_t n;
    if (tc == '0) begin
      n = ring_n_t'(1);
    end else if (int'(tc) > MAX_THREADS) begin
      n = ring_n_t'(MAX_THREADS);
    end else begin
      n = ring_n_t'(tc);
    end
    return n;
  endfunction

  function automatic idx_t ring_next(input idx_t idx, input ring_n_t n);
    ring_n_t t;
    t = {1'b0, idx} + ring_n_t'(1);
    return (t >= n) ? '0 : t[IDX_W-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/rrss_if.sv
`default_nettype none
interface rrss_in_if;
  import rrss_pkg::*;
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [TID_W-1:0]    thread_index;
  logic [TIME_W-1:0]   wake_time;
  logic [TIME_W-1:0]   current_time;

  modport source (output valid, func, thread_index, wake_time, current_time, input ready);
  modport sink   (input valid, func, thread_index, wake_time, current_time, output ready);
endinterface

interface rrss_out_if;
  import rrss_pkg::*;
  logic             valid;
  logic             ready;
  logic [TID_W-1:0] next_thread;
  logic             switch_request;
  logic [TID_W-1:0] current_thread;
  logic             current_valid;

  modport source (output valid, next_thread, switch_request, current_thread, current_valid,
                  input ready);
  modport sink   (input valid, next_thread, switch_request, current_thread, current_valid,
                  output ready);
endinterface
`default_nettype wire

FILE: rtl/rrss_wake_store.sv
`default_nettype none
module rrss_wake_store
  import rrss_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire wake_wr_t wr,
  input  wire idx_t     rd_addr,
  output time_t         rd_data
);

  time_t                  mem_r [MAX_THREADS];
  logic [MAX_THREADS-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr.en) begin
      vld_r[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr.addr] <= wr.data;
    end
  end

  // entries never written read as awake
  assign rd_data = vld_r[rd_addr] ? mem_r[rd_addr] : '0;

endmodule
`default_nettype wire

FILE: rtl/rrss_scan_unit.sv
`default_nettype none
module rrss_scan_unit
  import rrss_pkg::*;
(
  input  wire time_t   now,
  input  wire time_t   wake,
  input  wire idx_t    pick,
  input  wire ring_n_t n,
  output scan_res_t    res
);

  // thread sleeps while now is before its wake time
  assign res.awake = !(now < wake);
  assign res.adv   = ring_next(pick, n);

endmodule
`default_nettype wire

FILE: rtl/round_robin_sleep_scheduler.sv
`default_nettype none
// round-robin sleep scheduler
// in_ch carries one word per request: func selects schedule tick, set wake
// time or context switch done; thread_index and wake_time serve set wake,
// current_time serves the tick. out_ch returns one word per request with
// the pick, the switch request and the running thread.
// cfg_we/cfg_wdata write thread_count; write it only while the block is idle.
// set wake, switch done and the unused code answer in the cycle after accept.
// a tick scans the ring one wake time per cycle through a single 64-bit
// compare and stops at the first awake thread or when the scan counter
// reaches its bound.
// one request is in flight at a time: in_ch.ready stays low while a tick
// scans and while a result word waits on out_ch, so a stalled receiver
// holds the block and the result word stays unchanged until taken.
// reset clears all wake times (every thread awake), sets the pick and the
// running thread to idle, clears current_valid and sets thread_count to 1.
module round_robin_sleep_scheduler
  import rrss_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  rrss_in_if.sink                in_ch,
  rrss_out_if.source             out_ch,
  input  wire logic              cfg_we,
  input  wire logic [TCNT_W-1:0] cfg_wdata
);

  typedef enum logic {ST_IDLE, ST_SCAN} state_t;

  state_t            st_r, st_nxt;
  logic [TCNT_W-1:0] tcnt_r;
  idx_t              next_idx_r, next_idx_nxt;
  idx_t              run_idx_r, run_idx_nxt;
  logic              run_vld_r, run_vld_nxt;
  logic              req_r, req_nxt;
  logic              out_vld_r, out_vld_nxt;
  idx_t              pick_r, pick_nxt;
  idx_t              cnt_r, cnt_nxt;
  time_t             now_r;

  ring_n_t   ring_n;
  idx_t      first_a, first_pick, fin_pick;
  logic      accept;
  wake_wr_t  wr;
  time_t     wake_rd;
  scan_res_t scan;

  assign ring_n     = ring_size(tcnt_r);
  assign first_a    = ring_next(next_idx_r, ring_n);
  assign first_pick = (first_a == '0) ? ring_next(first_a, ring_n) : first_a;

  assign in_ch.ready = (st_r == ST_IDLE) && !out_vld_r;
  assign accept      = in_ch.valid && in_ch.ready;

  assign wr.en   = accept && (in_ch.func == FUNC_WAKE) && (in_ch.thread_index != '0)
                   && (int'(in_ch.thread_index) < MAX_THREADS);
  assign wr.addr = idx_t'(in_ch.thread_index);
  assign wr.data = in_ch.wake_time;

  rrss_wake_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (wr),
    .rd_addr (pick_r),
    .rd_data (wake_rd)
  );

  rrss_scan_unit u_scan (
    .now  (now_r),
    .wake (wake_rd),
    .pick (pick_r),
    .n    (ring_n),
    .res  (scan)
  );

  assign fin_pick = scan.awake ? pick_r : scan.adv;

  always_comb begin
    st_nxt       = st_r;
    next_idx_nxt = next_idx_r;
    run_idx_nxt  = run_idx_r;
    run_vld_nxt  = run_vld_r;
    req_nxt      = req_r;
    out_vld_nxt  = out_vld_r;
    pick_nxt     = pick_r;
    cnt_nxt      = cnt_r;
    if (out_vld_r && out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end
    case (st_r)
      ST_IDLE: begin
        if (accept) begin
          req_nxt = 1'b0;
          case (in_ch.func)
            FUNC_TICK: begin
              st_nxt   = ST_SCAN;
              pick_nxt = first_pick;
              cnt_nxt  = '0;
            end
            FUNC_DONE: begin
              run_idx_nxt = next_idx_r;
              run_vld_nxt = 1'b1;
              out_vld_nxt = 1'b1;
            end
            default: begin
              out_vld_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (scan.awake || cnt_r == idx_t'(MAX_THREADS - 1)) begin
          st_nxt       = ST_IDLE;
          next_idx_nxt = fin_pick;
          req_nxt      = !run_vld_r || (fin_pick != run_idx_r);
          out_vld_nxt  = 1'b1;
        end else begin
          pick_nxt = scan.adv;
          cnt_nxt  = cnt_r + idx_t'(1);
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= ST_IDLE;
      tcnt_r     <= TCNT_RESET;
      next_idx_r <= '0;
      run_idx_r  <= '0;
      run_vld_r  <= 1'b0;
      req_r      <= 1'b0;
      out_vld_r  <= 1'b0;
      pick_r     <= '0;
      cnt_r      <= '0;
    end else begin
      st_r       <= st_nxt;
      next_idx_r <= next_idx_nxt;
      run_idx_r  <= run_idx_nxt;
      run_vld_r  <= run_vld_nxt;
      req_r      <= req_nxt;
      out_vld_r  <= out_vld_nxt;
      pick_r     <= pick_nxt;
      cnt_r      <= cnt_nxt;
      if (cfg_we) begin
        tcnt_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      now_r <= in_ch.current_time;
    end
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.next_thread    = TID_W'(next_idx_r);
  assign out_ch.switch_request = req_r;
  assign out_ch.current_thread = TID_W'(run_idx_r);
  assign out_ch.current_valid  = run_vld_r;

  a_no_accept_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_SCAN |-> !in_ch.ready)
    else $error("input accepted during scan");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_SCAN |-> cnt_r <= idx_t'(MAX_THREADS - 1))
    else $error("scan ran past ring bound");

  a_req_only_tick: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) && req_r |-> $past(st_r == ST_SCAN))
    else $error("switch request without tick");

  a_run_vld_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    run_vld_r |=> run_vld_r)
    else $error("current_valid dropped");

  a_pick_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) && $past(st_r == ST_SCAN) |-> {1'b0, next_idx_r} < ring_n)
    else $error("pick outside ring");

endmodule
`default_nettype wire

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import rrss_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 400;
  localparam int IDLE_LIMIT  = 50000;

  typedef struct packed {
    idx_t next_thread;
    logic switch_request;
    idx_t current_thread;
    logic current_valid;
  } pick_word_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [TCNT_W-1:0] cfg_wdata;

  rrss_in_if  in_ch();
  rrss_out_if out_ch();

  round_robin_sleep_scheduler DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // scheduler state as predicted
  time_t             wake_at [MAX_THREADS];
  idx_t              next_pick;
  idx_t              run_thread;
  logic              run_valid;
  logic [TCNT_W-1:0] thread_cnt;

  pick_word_t pending [$];
  pick_word_t want;

  time_t clock_base;
  bit    no_gaps;
  bit    hold_go;
  bit    hold_seen;
  int    hold_left;
  int    mismatches;
  int    leftovers;
  int    words_sent;
  int    words_checked;
  int    cfg_writes;
  int    skip_ticks;
  int    req_count;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic int ring_len(input logic [TCNT_W-1:0] tc);
    if (tc == 0) begin
      return 1;
    end
    return (int'(tc) > MAX_THREADS) ? MAX_THREADS : int'(tc);
  endfunction

  function automatic idx_t ring_step(input idx_t idx, input int n);
    return (int'(idx) + 1 >= n) ? idx_t'(0) : idx_t'(idx + 1);
  endfunction

  function automatic pick_word_t sched_step(input logic [FUNC_W-1:0] f, input idx_t tid,
                                            input time_t wk, input time_t now);
    int         n;
    int         scans;
    idx_t       pick;
    logic       req;
    pick_word_t w;
    n = ring_len(thread_cnt);
    req = 1'b0;
    case (f)
      FUNC_TICK: begin
        pick = ring_step(next_pick, n);
        if (pick == 0) begin
          pick = ring_step(pick, n);
        end
        for (scans = 0; scans < MAX_THREADS; scans++) begin
          if (!(now < wake_at[pick])) break;
          pick = ring_step(pick, n);
        end
        if (scans > 0) skip_ticks++;
        next_pick = pick;
        req = !run_valid || (next_pick != run_thread);
        if (req) req_count++;
      end
      FUNC_WAKE: begin
        if (tid != 0 && int'(tid) < MAX_THREADS) begin
          wake_at[tid] = wk;
        end
      end
      FUNC_DONE: begin
        run_thread = next_pick;
        run_valid  = 1'b1;
      end
      default: ;
    endcase
    w.next_thread    = next_pick;
    w.switch_request = req;
    w.current_thread = run_thread;
    w.current_valid  = run_valid;
    return w;
  endfunction

  function automatic time_t rand_time();
    return {$urandom, $urandom};
  endfunction

  function automatic void check_field(input string name, input logic [3:0] exp_v,
                                      input logic [3:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, got_v);
      mismatches++;
    end
  endfunction

  // result side: random stalls, long hold-off on request
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending.size() == 0) begin
        $display("%0t: unexpected word, expected none, got next %0d req %0d cur %0d cv %0d",
                 $time, out_ch.next_thread, out_ch.switch_request,
                 out_ch.current_thread, out_ch.current_valid);
        mismatches++;
      end else begin
        want = pending.pop_front();
        check_field("next_thread", want.next_thread, out_ch.next_thread);
        check_field("switch_request", 4'(want.switch_request), 4'(out_ch.switch_request));
        check_field("current_thread", want.current_thread, out_ch.current_thread);
        check_field("current_valid", 4'(want.current_valid), 4'(out_ch.current_valid));
        words_checked++;
      end
    end
    if (hold_go != hold_seen) begin
      hold_seen = hold_go;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= no_gaps || ($urandom_range(99) >= 8);
    end
  end

  task automatic send_word(input logic [FUNC_W-1:0] f, input idx_t tid, input time_t wk,
                           input time_t now);
    pick_word_t w;
    while (!no_gaps && $urandom_range(99) < 8) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.func         <= f;
    in_ch.thread_index <= tid;
    in_ch.wake_time    <= wk;
    in_ch.current_time <= now;
    do @(posedge clk); while (!in_ch.ready);
    w = sched_step(f, tid, wk, now);
    pending.push_back(w);
    words_sent++;
  endtask

  task automatic wait_idle();
    int guard;
    guard = 0;
    in_ch.valid <= 1'b0;
    while (pending.size() != 0 && guard < IDLE_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    if (pending.size() != 0) begin
      $display("%0t: %0d expected words never arrived", $time, pending.size());
      leftovers += pending.size();
      pending.delete();
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic set_thread_count(input logic [TCNT_W-1:0] v);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we     <= 1'b0;
    thread_cnt  = v;
    cfg_writes++;
  endtask

  // one scheduling round: wake writes, a tick, usually a switch done
  task automatic send_round();
    int   n;
    int   k;
    int   nw;
    idx_t tid;
    n = ring_len(thread_cnt);
    nw = $urandom_range(0, 3);
    for (k = 0; k < nw; k++) begin
      if (n > 1 && $urandom_range(9) < 8) begin
        tid = idx_t'($urandom_range(1, n - 1));
      end else begin
        tid = idx_t'($urandom_range(0, 15));
      end
      send_word(FUNC_WAKE, tid, clock_base + time_t'($urandom_range(0, 48)), rand_time());
    end
    clock_base += time_t'($urandom_range(0, 16));
    send_word(FUNC_TICK, idx_t'($urandom), rand_time(), clock_base);
    if ($urandom_range(9) < 8) begin
      send_word(FUNC_DONE, idx_t'($urandom), rand_time(), rand_time());
    end
  endtask

  task automatic send_noise();
    time_t now;
    case ($urandom_range(0, 3))
      0: now = '0;
      1: now = '1;
      default: now = rand_time();
    endcase
    send_word(FUNC_W'($urandom_range(0, 3)), idx_t'($urandom), rand_time(), now);
  endtask

  task automatic test_after_reset();
    send_word(FUNC_TICK, '0, '0, '0);
    send_word(FUNC_UNUSED, '0, '0, '0);
    send_word(FUNC_DONE, '0, '0, '0);
    send_word(FUNC_TICK, '0, '0, '1);
  endtask

  task automatic test_sleep_scan();
    set_thread_count(4);
    send_word(FUNC_WAKE, idx_t'(0), '1, '0);
    send_word(FUNC_WAKE, idx_t'(1), '1, '0);
    send_word(FUNC_WAKE, idx_t'(2), time_t'(5), '0);
    send_word(FUNC_WAKE, idx_t'(3), '0, '0);
    send_word(FUNC_TICK, '0, '0, '0);
    send_word(FUNC_DONE, '0, '0, '0);
    send_word(FUNC_TICK, '0, '0, time_t'(5));
    send_word(FUNC_TICK, '0, '0, '1);
  endtask

  task automatic test_ring_resize();
    set_thread_count(2);
    send_word(FUNC_TICK, '0, '0, '0);
    send_word(FUNC_TICK, '0, '0, '1);
    send_word(FUNC_DONE, '0, '0, '0);
    set_thread_count(0);
    send_word(FUNC_TICK, '0, '0, '0);
    set_thread_count(31);
    send_word(FUNC_WAKE, idx_t'(15), '1, '0);
    send_word(FUNC_TICK, '0, '0, '0);
    send_word(FUNC_TICK, '0, '0, '0);
    set_thread_count(17);
    send_word(FUNC_WAKE, idx_t'(3), '1, '0);
    send_word(FUNC_TICK, '0, '0, '0);
  endtask

  task automatic test_random_ring(input logic [TCNT_W-1:0] tc, input int words);
    int goal;
    set_thread_count(tc);
    goal = words_sent + words;
    while (words_sent < goal) begin
      if ($urandom_range(49) == 0) begin
        clock_base = rand_time();
      end
      if ($urandom_range(99) < 75) begin
        send_round();
      end else begin
        send_noise();
      end
    end
  endtask

  task automatic test_no_gaps();
    no_gaps = 1'b1;
    test_random_ring(8, 200);
    no_gaps = 1'b0;
  endtask

  task automatic test_backpressure();
    wait_idle();
    hold_go = ~hold_go;
    test_random_ring(5, 60);
  endtask

  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    in_ch.valid        = 1'b0;
    in_ch.func         = '0;
    in_ch.thread_index = '0;
    in_ch.wake_time    = '0;
    in_ch.current_time = '0;
    out_ch.ready       = 1'b0;
    for (int i = 0; i < MAX_THREADS; i++) wake_at[i] = '0;
    next_pick     = '0;
    run_thread    = '0;
    run_valid     = 1'b0;
    thread_cnt    = TCNT_RESET;
    clock_base    = '0;
    no_gaps       = 1'b0;
    hold_go       = 1'b0;
    hold_seen     = 1'b0;
    hold_left     = 0;
    mismatches    = 0;
    leftovers     = 0;
    words_sent    = 0;
    words_checked = 0;
    cfg_writes    = 0;
    skip_ticks    = 0;
    req_count     = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_after_reset();
    test_sleep_scan();
    test_ring_resize();
    test_random_ring(16, 250);
    test_random_ring(3, 150);
    test_no_gaps();
    test_random_ring(2, 120);
    test_random_ring(31, 150);
    test_backpressure();
    test_random_ring(17, 150);
    test_random_ring(12, 200);
    test_random_ring(0, 80);
    test_random_ring(1, 80);
    test_random_ring(16, 300);

    wait_idle();
    repeat (20) @(posedge clk);
    $display("sent %0d words and checked %0d results over %0d thread-count writes",
             words_sent, words_checked, cfg_writes);
    $display("%0d ticks skipped sleeping threads, %0d switch requests raised",
             skip_ticks, req_count);
    if (mismatches == 0 && leftovers == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/rrss_pkg.sv
rtl/rrss_if.sv
rtl/rrss_wake_store.sv
rtl/rrss_scan_unit.sv
rtl/round_robin_sleep_scheduler.sv
tb/sv/tb.sv
